// File: rtl/fbpa_pkg.sv
// fbpa_pkg: shared types and codes for the fixed block pool allocator
// no dependencies; imported by fixed_block_pool_allocator_top
package fbpa_pkg;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_EXHAUSTED = 2'd1;
	localparam status_t ST_OVERSIZE  = 2'd2;

	// request kinds
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// register word indexes
	localparam logic REG_OBJECT_SIZE = 1'b0;
	localparam logic REG_POOL_BLOCKS = 1'b1;

	// field widths
	localparam int OBJ_W    = 13;
	localparam int POOL_W   = 9;
	localparam int REQ_W    = 16;
	localparam int IDX_W    = 8;
	localparam int OFS_W    = 20;
	localparam int INUSE_W  = 9;
	localparam int CNT_W    = 32;

	// register reset values
	localparam logic [OBJ_W-1:0]  OBJ_SIZE_RESET   = 13'd64;
	localparam logic [POOL_W-1:0] POOL_BLOCKS_RESET = 9'd256;

	// smallest block size, one pointer
	localparam int PTR_BYTES = 8;

endpackage

// File: rtl/fixed_block_pool_allocator_top.sv
// fixed_block_pool_allocator_top: lifo free list block allocator with bump index
// depends on fbpa_pkg and fbpa_ram (next link store)
//
//  channel   handshake                    payload
//  request   start, busy                  action, request_size, block_index
//  result    done (one cycle, no stall)   granted_index, block_offset, status,
//                                         blocks_in_use, allocation_count, free_count
//  config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// a request is taken when start is high and busy is low; its result beat shows on
// done in the next cycle. a free, an error and a bump allocation leave busy low.
// an allocation popped from the free list holds busy high for one cycle while the
// next link of the popped block comes back from the link ram.
// reset clears all control state; link ram entries are written before use.
// results cannot be held off, so nothing ever stalls on the result side.
module fixed_block_pool_allocator_top #(
	parameter int NUM_BLOCKS = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// request
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   action,
	input  logic [fbpa_pkg::REQ_W-1:0]             request_size,
	input  logic [fbpa_pkg::IDX_W-1:0]             block_index,
	// result
	output logic                                   done,
	output logic [fbpa_pkg::IDX_W-1:0]             granted_index,
	output logic [fbpa_pkg::OFS_W-1:0]             block_offset,
	output fbpa_pkg::status_t                      status,
	output logic [fbpa_pkg::INUSE_W-1:0]           blocks_in_use,
	output logic [fbpa_pkg::CNT_W-1:0]             allocation_count,
	output logic [fbpa_pkg::CNT_W-1:0]             free_count,
	// configuration
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [2:0]                             paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	import fbpa_pkg::*;

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int LW = $clog2(NUM_BLOCKS + 1);
	localparam logic [LW-1:0] EMPTY = LW'(NUM_BLOCKS);

	// configuration registers
	logic [OBJ_W-1:0]  object_size_q;
	logic [POOL_W-1:0] pool_blocks_q;

	// allocator state
	logic [LW-1:0]      head_q;
	logic [LW-1:0]      bump_q;
	logic [INUSE_W-1:0] in_use_q;
	logic [CNT_W-1:0]   alloc_cnt_q;
	logic [CNT_W-1:0]   free_cnt_q;
	logic               busy_q;

	// result registers
	logic               done_q;
	logic [IDX_W-1:0]   granted_q;
	logic [OFS_W-1:0]   offset_q;
	status_t            status_q;

	// link ram
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [IW-1:0]      ram_raddr;
	logic [LW-1:0]      ram_rdata_q;

	// request decode
	logic               accept;
	logic               cfg_wr;
	logic               free_ok;
	logic               oversize;
	logic               head_valid;
	logic               bump_ok;
	logic [31:0]        limit;
	logic [OBJ_W-1:0]   bsize;
	logic [IW-1:0]      grant_idx;
	logic               do_pop;
	logic               do_bump;
	logic               do_free;

	assign accept     = start && !busy_q;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign free_ok    = 32'(block_index) < NUM_BLOCKS;
	assign oversize   = request_size > {{(REQ_W-OBJ_W){1'b0}}, object_size_q};
	assign head_valid = head_q != EMPTY;
	assign limit      = (32'(pool_blocks_q) > NUM_BLOCKS) ? NUM_BLOCKS : 32'(pool_blocks_q);
	assign bump_ok    = 32'(bump_q) < limit;
	assign bsize      = (32'(object_size_q) < PTR_BYTES) ? OBJ_W'(PTR_BYTES) : object_size_q;

	assign do_free = accept && (action == ACT_FREE) && free_ok;
	assign do_pop  = accept && (action == ACT_ALLOC) && !oversize && head_valid;
	assign do_bump = accept && (action == ACT_ALLOC) && !oversize && !head_valid && bump_ok;

	assign grant_idx = head_valid ? head_q[IW-1:0] : bump_q[IW-1:0];

	// free pushes the old head into the freed block's link
	assign ram_we    = do_free;
	assign ram_waddr = IW'(block_index);
	assign ram_raddr = head_q[IW-1:0];

	fbpa_ram #(
		.WIDTH (LW),
		.DEPTH (NUM_BLOCKS)
	) u_link_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (head_q),
		.raddr   (ram_raddr),
		.rdata_q (ram_rdata_q)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_size_q <= OBJ_SIZE_RESET;
			pool_blocks_q <= POOL_BLOCKS_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_OBJECT_SIZE) begin
				object_size_q <= pwdata[OBJ_W-1:0];
			end else begin
				pool_blocks_q <= pwdata[POOL_W-1:0];
			end
		end
	end

	// configuration read back
	always_comb begin
		if (paddr[2] == REG_OBJECT_SIZE) begin
			prdata = {{(32-OBJ_W){1'b0}}, object_size_q};
		end else begin
			prdata = {{(32-POOL_W){1'b0}}, pool_blocks_q};
		end
	end

	assign pready = 1'b1;

	// free list head, bump index and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= EMPTY;
			bump_q      <= '0;
			in_use_q    <= '0;
			alloc_cnt_q <= '0;
			free_cnt_q  <= '0;
			busy_q      <= 1'b0;
		end else begin
			busy_q <= do_pop;
			// link of the popped block arrives from the ram read port in the cycle after the pop
			if (busy_q) begin
				head_q <= ram_rdata_q;
			end else if (do_free) begin
				head_q <= LW'(block_index);
			end
			if (do_bump) begin
				bump_q <= bump_q + 1'b1;
			end
			if (do_pop || do_bump) begin
				in_use_q    <= in_use_q + 1'b1;
				alloc_cnt_q <= alloc_cnt_q + 1'b1;
			end else if (do_free) begin
				in_use_q   <= in_use_q - 1'b1;
				free_cnt_q <= free_cnt_q + 1'b1;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// result payload, offset product registered here
	always_ff @(posedge clk) begin
		if (accept) begin
			if (do_pop || do_bump) begin
				granted_q <= IDX_W'(grant_idx);
				offset_q  <= OFS_W'(grant_idx) * OFS_W'(bsize);
				status_q  <= ST_OK;
			end else begin
				granted_q <= '0;
				offset_q  <= '0;
				if (action == ACT_FREE) begin
					status_q <= ST_OK;
				end else if (oversize) begin
					status_q <= ST_OVERSIZE;
				end else begin
					status_q <= ST_EXHAUSTED;
				end
			end
		end
	end

	assign busy             = busy_q;
	assign done             = done_q;
	assign granted_index    = granted_q;
	assign block_offset     = offset_q;
	assign status           = status_q;
	assign blocks_in_use    = in_use_q;
	assign allocation_count = alloc_cnt_q;
	assign free_count       = free_cnt_q;

endmodule

// File: rtl/fbpa_ram.sv
// fbpa_ram: generic single write, single read ram with registered read data
// no dependencies; holds the free list links
module fbpa_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for fixed_block_pool_allocator_top, request beats in, result beats checked
// depends on fbpa_pkg and the allocator rtl; keeps its own free list and bump index to predict beats
module tb;
	import fbpa_pkg::*;

	localparam int POOL_DEPTH = 256;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [OFS_W-1:0]   ofs;
		status_t            st;
		logic [INUSE_W-1:0] in_use;
		logic [CNT_W-1:0]   allocs;
		logic [CNT_W-1:0]   frees;
	} pool_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic action;
	logic [REQ_W-1:0] request_size;
	logic [IDX_W-1:0] block_index;
	logic done;
	logic [IDX_W-1:0] granted_index;
	logic [OFS_W-1:0] block_offset;
	status_t status;
	logic [INUSE_W-1:0] blocks_in_use;
	logic [CNT_W-1:0] allocation_count;
	logic [CNT_W-1:0] free_count;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// predicted allocator state
	logic [8:0] link_mem [POOL_DEPTH];
	logic [8:0] free_head;
	logic [8:0] bump_next;
	logic [INUSE_W-1:0] in_use_now;
	logic [CNT_W-1:0] allocs_now;
	logic [CNT_W-1:0] frees_now;
	logic [OBJ_W-1:0] obj_size_reg;
	logic [POOL_W-1:0] pool_blocks_reg;

	pool_result_t pending_results[$];
	logic [IDX_W-1:0] held_blocks[$];
	int errors;
	int cycles;
	bit quiet;

	fixed_block_pool_allocator_top #(
		.NUM_BLOCKS(POOL_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.request_size(request_size),
		.block_index(block_index),
		.done(done),
		.granted_index(granted_index),
		.block_offset(block_offset),
		.status(status),
		.blocks_in_use(blocks_in_use),
		.allocation_count(allocation_count),
		.free_count(free_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one request applied to the predicted pool, returns the beat it causes
	function automatic pool_result_t pool_step(logic act, logic [REQ_W-1:0] size,
			logic [IDX_W-1:0] idx);
		pool_result_t r;
		logic [8:0] limit;
		logic [12:0] bsize;
		logic [8:0] grant;
		logic [31:0] product;
		bit granted;
		r = '0;
		r.st = ST_OK;
		granted = 1'b0;
		grant = '0;
		if (act == ACT_FREE) begin
			link_mem[idx] = free_head;
			free_head = {1'b0, idx};
			in_use_now = in_use_now - 1'b1;
			frees_now = frees_now + 1'b1;
		end else if ({3'b000, size} > {6'd0, obj_size_reg}) begin
			r.st = ST_OVERSIZE;
		end else begin
			limit = (pool_blocks_reg > POOL_DEPTH) ? 9'(POOL_DEPTH) : pool_blocks_reg;
			if (free_head < POOL_DEPTH) begin
				grant = free_head;
				free_head = link_mem[grant[7:0]];
				granted = 1'b1;
			end else if (bump_next < limit) begin
				grant = bump_next;
				bump_next = bump_next + 1'b1;
				granted = 1'b1;
			end else begin
				r.st = ST_EXHAUSTED;
			end
		end
		if (granted) begin
			bsize = (obj_size_reg < PTR_BYTES) ? 13'(PTR_BYTES) : obj_size_reg;
			product = {23'd0, grant} * {19'd0, bsize};
			in_use_now = in_use_now + 1'b1;
			allocs_now = allocs_now + 1'b1;
			r.idx = grant[7:0];
			r.ofs = product[OFS_W-1:0];
		end
		r.in_use = in_use_now;
		r.allocs = allocs_now;
		r.frees = frees_now;
		return r;
	endfunction

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 12);
	endfunction

	// one request beat: hold start until accepted, predict, then for a nonzero gap drop start and idle
	task automatic send_request(input logic act, input logic [REQ_W-1:0] size,
			input logic [IDX_W-1:0] idx, input int gap);
		pool_result_t r;
		@(negedge clk);
		start = 1'b1;
		action = act;
		request_size = size;
		block_index = idx;
		do @(posedge clk); while (busy);
		r = pool_step(act, size, idx);
		pending_results.push_back(r);
		if (act == ACT_ALLOC && r.st == ST_OK)
			held_blocks.push_back(r.idx);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop issuing and wait until every predicted beat has come back
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write, then read back and compare the register bits
	task automatic write_reg(input logic which, input logic [31:0] value);
		logic [31:0] want;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {which, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (which == REG_OBJECT_SIZE) begin
			obj_size_reg = value[OBJ_W-1:0];
			want = {19'd0, obj_size_reg};
		end else begin
			pool_blocks_reg = value[POOL_W-1:0];
			want = {23'd0, pool_blocks_reg};
		end
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if ((which == REG_OBJECT_SIZE && prdata[OBJ_W-1:0] != want[OBJ_W-1:0]) ||
				(which == REG_POOL_BLOCKS && prdata[POOL_W-1:0] != want[POOL_W-1:0])) begin
			$display("%0t readback reg %0d expected %0d actual %0d", $time, which, want,
				prdata);
			errors++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// result beat checker
	always @(posedge clk) begin
		pool_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result beat: expected none actual index %0d status %0d",
					$time, granted_index, status);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (granted_index !== e.idx) begin
					$display("%0t granted_index expected %0d actual %0d", $time, e.idx,
						granted_index);
					errors++;
				end
				if (block_offset !== e.ofs) begin
					$display("%0t block_offset expected %0d actual %0d", $time, e.ofs,
						block_offset);
					errors++;
				end
				if (status !== e.st) begin
					$display("%0t status expected %0d actual %0d", $time, e.st, status);
					errors++;
				end
				if (blocks_in_use !== e.in_use) begin
					$display("%0t blocks_in_use expected %0d actual %0d", $time, e.in_use,
						blocks_in_use);
					errors++;
				end
				if (allocation_count !== e.allocs) begin
					$display("%0t allocation_count expected %0d actual %0d", $time, e.allocs,
						allocation_count);
					errors++;
				end
				if (free_count !== e.frees) begin
					$display("%0t free_count expected %0d actual %0d", $time, e.frees,
						free_count);
					errors++;
				end
			end
		end
	end

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// size limits, freeing with nothing in use, lifo order of the free list
	task automatic test_after_reset();
		send_request(ACT_FREE, 16'd0, 8'd3, 0);
		send_request(ACT_ALLOC, 16'd0, 8'd0, 0);
		send_request(ACT_ALLOC, 16'd64, 8'd0, 1);
		send_request(ACT_ALLOC, 16'd65, 8'd0, 0);
		send_request(ACT_ALLOC, 16'hffff, 8'hff, 2);
		send_request(ACT_FREE, 16'hffff, 8'd255, 0);
		send_request(ACT_FREE, 16'd0, 8'd0, 0);
		send_request(ACT_FREE, 16'd0, 8'd0, 3);
		send_request(ACT_ALLOC, 16'd1, 8'd0, 0);
		send_request(ACT_ALLOC, 16'd1, 8'd0, 0);
		send_request(ACT_ALLOC, 16'd1, 8'd0, 0);
		send_request(ACT_ALLOC, 16'd1, 8'd0, 0);
		settle();
	endtask

	// empty free list and bump index at its limit, then a zero pool count
	task automatic test_exhaustion();
		int guard;
		write_reg(REG_POOL_BLOCKS, 32'(bump_next) + 32'd1);
		guard = 0;
		while (free_head < POOL_DEPTH && guard < POOL_DEPTH) begin
			send_request(ACT_ALLOC, 16'd8, 8'd0, 0);
			guard++;
		end
		send_request(ACT_ALLOC, 16'd8, 8'd0, 0);
		send_request(ACT_ALLOC, 16'd8, 8'd0, 1);
		settle();
		write_reg(REG_POOL_BLOCKS, 32'd0);
		send_request(ACT_ALLOC, 16'd0, 8'd0, 0);
		send_request(ACT_FREE, 16'd0, 8'd17, 0);
		send_request(ACT_ALLOC, 16'd0, 8'd0, 0);
		settle();
	endtask

	// object size at its largest: offset of a high block no longer fits 20 bits
	task automatic test_offset_overflow();
		write_reg(REG_OBJECT_SIZE, 32'hffff_ffff);
		write_reg(REG_POOL_BLOCKS, 32'hffff_ffff);
		send_request(ACT_FREE, 16'd0, 8'd255, 0);
		send_request(ACT_ALLOC, 16'd8191, 8'd0, 0);
		send_request(ACT_ALLOC, 16'd8192, 8'd0, 0);
		settle();
		held_blocks.delete();
	endtask

	// mostly matched alloc and free beats, with noise frees and oversize requests
	task automatic test_random_mix(input logic [31:0] obj, input logic [31:0] pool,
			input int count);
		int run_left;
		int pick;
		int pos;
		logic [REQ_W-1:0] size;
		logic [IDX_W-1:0] idx;
		write_reg(REG_OBJECT_SIZE, obj);
		write_reg(REG_POOL_BLOCKS, pool);
		run_left = 0;
		for (int n = 0; n < count; n++) begin
			if (run_left == 0) begin
				quiet = ($urandom_range(0, 2) == 0);
				run_left = $urandom_range(20, 60);
			end
			run_left--;
			pick = $urandom_range(0, 99);
			size = '0;
			idx = '0;
			if (pick < 8) begin
				size = REQ_W'($urandom_range({19'd0, obj_size_reg} + 1, 65535));
				send_request(ACT_ALLOC, size, REQ_W'($urandom), draw_gap());
			end else if (pick < 14) begin
				send_request(ACT_FREE, REQ_W'($urandom), IDX_W'($urandom), draw_gap());
			end else if (pick < 17) begin
				send_request(ACT_ALLOC, REQ_W'($urandom), IDX_W'($urandom), draw_gap());
			end else if (held_blocks.size() == 0 || pick < 60) begin
				size = REQ_W'($urandom_range(0, {19'd0, obj_size_reg}));
				send_request(ACT_ALLOC, size, IDX_W'($urandom), draw_gap());
			end else begin
				pos = $urandom_range(0, held_blocks.size() - 1);
				idx = held_blocks[pos];
				held_blocks.delete(pos);
				send_request(ACT_FREE, REQ_W'($urandom), idx, draw_gap());
			end
		end
		quiet = 1'b0;
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_ALLOC;
		request_size = '0;
		block_index = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		for (int i = 0; i < POOL_DEPTH; i++) link_mem[i] = '0;
		free_head = 9'(POOL_DEPTH);
		bump_next = '0;
		in_use_now = '0;
		allocs_now = '0;
		frees_now = '0;
		obj_size_reg = OBJ_SIZE_RESET;
		pool_blocks_reg = POOL_BLOCKS_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_exhaustion();
		test_offset_overflow();
		test_random_mix(32'd4096, 32'd511, 230);
		test_random_mix(32'd1, 32'd256, 220);
		test_random_mix(32'd0, 32'd1, 220);
		test_random_mix(32'd8191, 32'd300, 220);
		test_random_mix(32'd64, 32'd128, 230);
		test_random_mix(32'd13, 32'd256, 230);

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fixed_block_pool_allocator_top.sv
bench/tb.sv
